// ===== hdl/mis_pkg.sv =====
package mis_pkg;

  // Width of one list element.
  localparam int unsigned ValueW = 31;

  // Default capacity of the insertion chain.
  localparam int unsigned MaxItemsDef = 32;

  // Control that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic insert;  // Place the broadcast element into the chain.
    logic shift;   // Move every element one cell toward the output.
  } cell_ctrl_t;

endpackage

// ===== hdl/mis_cell.sv =====
module mis_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mis_pkg::cell_ctrl_t           ctrl_i,
  input  logic [mis_pkg::ValueW-1:0]    new_value_i,
  input  logic                          left_stay_i,
  input  logic [mis_pkg::ValueW-1:0]    left_value_i,
  input  logic                          left_valid_i,
  input  logic [mis_pkg::ValueW-1:0]    right_value_i,
  input  logic                          right_valid_i,
  output logic                          stay_o,
  output logic [mis_pkg::ValueW-1:0]    value_o,
  output logic                          valid_o
);
  import mis_pkg::*;

  logic [ValueW-1:0] value_q, value_d;
  logic              valid_q, valid_d;

  // The held element stays in place when it is not larger than the new one,
  // so equal values keep their arrival order.
  assign stay_o = valid_q && (value_q <= new_value_i);

  // Next content of the cell: keep, take the new element, take the left
  // neighbor's element on an insert, or the right neighbor's on a shift.
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      if (!stay_o) begin
        if (left_stay_i) begin
          value_d = new_value_i;
          valid_d = 1'b1;
        end else begin
          value_d = left_value_i;
          valid_d = left_valid_i;
        end
      end
    end else if (ctrl_i.shift) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end
  end

  // The valid bit is control state; the element needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ===== hdl/merge_insertion_sorter_top.sv =====
// After the element marked last is taken, the first sorted result appears in the
// following cycle.
// Throughput: one element per cycle while loading (busy low); a list of held
// elements is then emitted one result per cycle, from cell 0.
// Reset: the chain and the drop flag are cleared; the receiver cannot stall and
// takes every result in the cycle of its strobe.
module merge_insertion_sorter_top #(
  parameter int unsigned MAX_ITEMS = mis_pkg::MaxItemsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mis_pkg::ValueW-1:0]    item_value_i,
  input  logic                          item_last_i,
  output logic                          result_strobe_o,
  output logic [mis_pkg::ValueW-1:0]    sorted_value_o,
  output logic                          sorted_last_o,
  output logic                          overflow_o
);
  import mis_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_ITEMS);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              dropped_q, dropped_d;
  logic              accept;
  logic              full;
  cell_ctrl_t        ctrl;

  logic [ValueW-1:0] cell_value [MAX_ITEMS];
  logic              cell_valid [MAX_ITEMS];
  logic              cell_stay  [MAX_ITEMS];

  assign busy   = (state_q == ST_EMIT);
  assign accept = start && !busy;
  assign full   = (count_q == CntFull);

  // Insert a transfer unless the chain is full; shift out while emitting.
  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = busy;

  // Chain of cells, cell 0 holding the smallest element.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic              left_stay;
    logic [ValueW-1:0] left_value;
    logic              left_valid;
    logic [ValueW-1:0] right_value;
    logic              right_valid;

    if (i == 0) begin : g_head
      assign left_stay  = 1'b1;
      assign left_value = item_value_i;
      assign left_valid = 1'b0;
    end else begin : g_body
      assign left_stay  = cell_stay[i-1];
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    mis_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_value_i   (item_value_i),
      .left_stay_i   (left_stay),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .right_value_i (right_value),
      .right_valid_i (right_valid),
      .stay_o        (cell_stay[i]),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i])
    );
  end

  // Sequencer: count held elements while loading, count down while emitting.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            count_d = count_q + CntOne;
          end
          if (item_last_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        count_d = count_q - CntOne;
        if (count_q == CntOne) begin
          state_d   = ST_LOAD;
          dropped_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  // Results leave from the head of the chain.
  assign result_strobe_o = busy;
  assign sorted_value_o  = cell_value[0];
  assign sorted_last_o   = busy && (count_q == CntOne);
  assign overflow_o      = busy && dropped_q;

  // The head cell holds a valid element whenever a result is shown.
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> cell_valid[0])
    else $error("result shown from an empty head cell");

  // The final result of a list returns the block to loading.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sorted_last_o |=> !busy && (count_q == '0) && !dropped_q)
    else $error("list not cleared after its final result");

  // A non-final transfer into a chain with room grows the count by one.
  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !item_last_i && !full) |=> (count_q == $past(count_q) + CntOne))
    else $error("held count did not follow an insertion");

  // The count never exceeds the capacity of the chain.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("held count beyond capacity");

endmodule
